/* hdl/stt_pkg.sv */
// Package for the software timer table: request, status and error codes,
// default sizes and the result beat layout.
// No dependencies; every other file of the block uses it.
package stt_pkg;

   localparam int TimerCountDef = 8;
   localparam int TickBitsDef   = 16;

   localparam int ReqTypeW = 3;
   localparam int IdW      = 6;
   localparam int PresetW  = 16;
   localparam int StatusW  = 2;
   localparam int ErrorW   = 2;

   localparam logic [ReqTypeW-1:0] REQ_CREATE   = 3'd0;
   localparam logic [ReqTypeW-1:0] REQ_START    = 3'd1;
   localparam logic [ReqTypeW-1:0] REQ_STOP     = 3'd2;
   localparam logic [ReqTypeW-1:0] REQ_PAUSE    = 3'd3;
   localparam logic [ReqTypeW-1:0] REQ_CONTINUE = 3'd4;
   localparam logic [ReqTypeW-1:0] REQ_REMOVE   = 3'd5;
   localparam logic [ReqTypeW-1:0] REQ_STATUS   = 3'd6;
   localparam logic [ReqTypeW-1:0] REQ_TICK     = 3'd7;

   localparam logic [StatusW-1:0] ST_UNUSED = 2'd0;
   localparam logic [StatusW-1:0] ST_OFF    = 2'd1;
   localparam logic [StatusW-1:0] ST_ON     = 2'd2;
   localparam logic [StatusW-1:0] ST_PAUSED = 2'd3;

   localparam logic [ErrorW-1:0] ERR_NONE  = 2'd0;
   localparam logic [ErrorW-1:0] ERR_RANGE = 2'd1;
   localparam logic [ErrorW-1:0] ERR_FULL  = 2'd2;

   typedef struct packed {
      logic [IdW-1:0]     slot_id;
      logic [StatusW-1:0] slot_status;
      logic [ErrorW-1:0]  error_code;
      logic               fired;
      logic               last;
   } rsp_type;

endpackage

/* hdl/stt_if.sv */
// Valid/ready channel interfaces for the software timer table.
// Depends on stt_pkg for the field widths.
interface stt_req_if;
   logic                          valid;
   logic                          ready;
   logic [stt_pkg::ReqTypeW-1:0]  req_type;
   logic [stt_pkg::IdW-1:0]       timer_id;
   logic [stt_pkg::PresetW-1:0]   preset;
   logic                          cyclic;

   modport source (output valid, req_type, timer_id, preset, cyclic, input ready);
   modport sink   (input valid, req_type, timer_id, preset, cyclic, output ready);
endinterface

interface stt_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [stt_pkg::IdW-1:0]       slot_id;
   logic [stt_pkg::StatusW-1:0]   slot_status;
   logic [stt_pkg::ErrorW-1:0]    error_code;
   logic                          fired;
   logic                          last;

   modport source (output valid, slot_id, slot_status, error_code, fired, last,
                   input ready);
   modport sink   (input valid, slot_id, slot_status, error_code, fired, last,
                   output ready);
endinterface

/* hdl/software_timer_table_top.sv */
// Top level of the software timer table: sequencer, slot memory and result register.
// Depends on stt_pkg and on the channel interfaces in stt_if.sv.
//
// Usage: each request beat on req carries a request type, a slot id, a preset
// and a mode bit. Every request but tick answers with exactly one beat on rsp,
// with last set. A tick walks all slots in ascending order and answers with one
// beat per fired timer, last set on the final one; a tick that fires nothing
// answers with no beat at all.
// Timing: the slot table lives in a memory with a registered read port, and one
// sequencer walks it one slot per cycle while a tick is not held by rsp. A request
// on a single slot passes through the read, evaluate and flush states; create and
// tick walk the slots in turn, and create stops at the first free slot.
// req.ready is high only while the sequencer is idle, one request at a time.
// The result register sits between the sequencer and rsp, so a request can be
// accepted while the previous result still waits. When rsp stalls, a tick holds
// at the next slot that fires until the result register is free.
// Reset clears all per-slot valid bits at once, so every slot reads as unused
// with a zero preset and count; no clearing pass is needed.
module software_timer_table_top #(
   parameter int TIMER_COUNT = stt_pkg::TimerCountDef,
   parameter int TICK_BITS   = stt_pkg::TickBitsDef
) (
   input logic          clock,
   input logic          reset,
   stt_req_if.sink      req,
   stt_rsp_if.source    rsp
);

   localparam int IDX_W   = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
   localparam int ENTRY_W = stt_pkg::StatusW + 1 + 2 * TICK_BITS;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_COUNT - 1);

   typedef enum logic [1:0] {S_IDLE, S_READ, S_EVAL, S_FLUSH} state_type;

   state_type                     state_ff, state_in;
   logic [stt_pkg::ReqTypeW-1:0]  op_ff, op_in;
   logic [stt_pkg::IdW-1:0]       id_ff, id_in;
   logic [TICK_BITS-1:0]          preset_ff, preset_in;
   logic                          cyclic_ff, cyclic_in;
   logic [IDX_W-1:0]              idx_ff, idx_in;
   logic                          pend_valid_ff, pend_valid_in;
   stt_pkg::rsp_type              pend_ff, pend_in;
   logic                          out_valid_ff, out_valid_in;
   stt_pkg::rsp_type              out_ff, out_in;
   logic [TIMER_COUNT-1:0]        valid_ff, valid_in;

   logic [ENTRY_W-1:0]            slot_mem [TIMER_COUNT];
   logic [ENTRY_W-1:0]            rd_data_ff;
   logic                          mem_re, mem_we;
   logic [IDX_W-1:0]              rd_addr;
   logic [ENTRY_W-1:0]            wr_data;

   logic [ENTRY_W-1:0]            cur;
   logic [stt_pkg::StatusW-1:0]   cur_state, new_state;
   logic                          cur_cyc;
   logic [TICK_BITS-1:0]          cur_preset, cur_elapsed, inc, new_elapsed, new_preset;
   logic                          new_cyc;
   logic                          hit, is_last, out_free, is_walk;

   // A slot never written since reset reads as all zero, i.e. unused.
   assign cur         = valid_ff[idx_ff] ? rd_data_ff : '0;
   assign cur_state   = cur[ENTRY_W-1 -: stt_pkg::StatusW];
   assign cur_cyc     = cur[2*TICK_BITS];
   assign cur_preset  = cur[2*TICK_BITS-1 -: TICK_BITS];
   assign cur_elapsed = cur[TICK_BITS-1:0];
   assign inc         = cur_elapsed + TICK_BITS'(1);
   assign hit         = (cur_state == stt_pkg::ST_ON) && (inc == cur_preset);
   assign is_last     = (idx_ff == LAST_IDX);
   assign out_free    = !out_valid_ff || rsp.ready;
   assign is_walk     = (op_ff == stt_pkg::REQ_CREATE) || (op_ff == stt_pkg::REQ_TICK);
   assign wr_data     = {new_state, new_cyc, new_preset, new_elapsed};

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      preset_in     = preset_ff;
      cyclic_in     = cyclic_ff;
      idx_in        = idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      valid_in      = valid_ff;
      mem_re        = 1'b0;
      mem_we        = 1'b0;
      rd_addr       = idx_ff;
      new_state     = cur_state;
      new_cyc       = cur_cyc;
      new_preset    = cur_preset;
      new_elapsed   = cur_elapsed;

      if (out_valid_ff && rsp.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               op_in     = req.req_type;
               id_in     = req.timer_id;
               preset_in = TICK_BITS'(req.preset);
               cyclic_in = req.cyclic;
               if (req.req_type == stt_pkg::REQ_CREATE || req.req_type == stt_pkg::REQ_TICK) begin
                  idx_in   = '0;
                  state_in = S_READ;
               end else if ({1'b0, req.timer_id} >= 7'(TIMER_COUNT)) begin
                  pend_in       = '{slot_id: req.timer_id, slot_status: stt_pkg::ST_UNUSED,
                                    error_code: stt_pkg::ERR_RANGE, fired: 1'b0, last: 1'b1};
                  pend_valid_in = 1'b1;
                  state_in      = S_FLUSH;
               end else begin
                  idx_in   = req.timer_id[IDX_W-1:0];
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            mem_re   = 1'b1;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            case (op_ff)
               stt_pkg::REQ_CREATE: begin
                  new_state   = stt_pkg::ST_OFF;
                  new_cyc     = cyclic_ff;
                  new_elapsed = '0;
                  if (cur_state == stt_pkg::ST_UNUSED) begin
                     mem_we        = 1'b1;
                     pend_in       = '{slot_id: stt_pkg::IdW'(idx_ff),
                                       slot_status: stt_pkg::ST_OFF,
                                       error_code: stt_pkg::ERR_NONE, fired: 1'b0, last: 1'b1};
                     pend_valid_in = 1'b1;
                     state_in      = S_FLUSH;
                  end else if (is_last) begin
                     pend_in       = '{slot_id: '0, slot_status: stt_pkg::ST_UNUSED,
                                       error_code: stt_pkg::ERR_FULL, fired: 1'b0, last: 1'b1};
                     pend_valid_in = 1'b1;
                     state_in      = S_FLUSH;
                  end else begin
                     mem_re  = 1'b1;
                     rd_addr = idx_ff + IDX_W'(1);
                     idx_in  = idx_ff + IDX_W'(1);
                  end
               end
               stt_pkg::REQ_TICK: begin
                  new_elapsed = (hit && cur_cyc) ? '0 : inc;
                  new_state   = (hit && !cur_cyc) ? stt_pkg::ST_OFF : cur_state;
                  // A second fire needs the result register for the one before it.
                  if (!(hit && pend_valid_ff && !out_free)) begin
                     mem_we = (cur_state == stt_pkg::ST_ON);
                     if (hit) begin
                        if (pend_valid_ff) begin
                           out_in       = pend_ff;
                           out_in.last  = 1'b0;
                           out_valid_in = 1'b1;
                        end
                        pend_in       = '{slot_id: stt_pkg::IdW'(idx_ff), slot_status: new_state,
                                          error_code: stt_pkg::ERR_NONE, fired: 1'b1, last: 1'b1};
                        pend_valid_in = 1'b1;
                     end
                     if (is_last) begin
                        state_in = (hit || pend_valid_ff) ? S_FLUSH : S_IDLE;
                     end else begin
                        mem_re  = 1'b1;
                        rd_addr = idx_ff + IDX_W'(1);
                        idx_in  = idx_ff + IDX_W'(1);
                     end
                  end
               end
               default: begin
                  mem_we = 1'b1;
                  case (op_ff)
                     stt_pkg::REQ_REMOVE: begin
                        new_state   = stt_pkg::ST_UNUSED;
                        new_cyc     = 1'b0;
                        new_preset  = '0;
                        new_elapsed = '0;
                     end
                     stt_pkg::REQ_START: begin
                        if (cur_state != stt_pkg::ST_UNUSED) begin
                           new_state   = stt_pkg::ST_ON;
                           new_preset  = preset_ff;
                           new_elapsed = '0;
                        end
                     end
                     stt_pkg::REQ_STOP: begin
                        if (cur_state != stt_pkg::ST_UNUSED) new_state = stt_pkg::ST_OFF;
                     end
                     stt_pkg::REQ_PAUSE: begin
                        if (cur_state != stt_pkg::ST_UNUSED) new_state = stt_pkg::ST_PAUSED;
                     end
                     stt_pkg::REQ_CONTINUE: begin
                        if (cur_state != stt_pkg::ST_UNUSED) new_state = stt_pkg::ST_ON;
                     end
                     default: begin
                        // Status reads the slot back unchanged.
                     end
                  endcase
                  pend_in       = '{slot_id: id_ff, slot_status: new_state,
                                    error_code: stt_pkg::ERR_NONE, fired: 1'b0, last: 1'b1};
                  pend_valid_in = 1'b1;
                  state_in      = S_FLUSH;
               end
            endcase
            if (mem_we) begin
               valid_in[idx_ff] = 1'b1;
            end
         end
         S_FLUSH: begin
            if (out_free) begin
               out_in        = pend_ff;
               out_in.last   = 1'b1;
               out_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         valid_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         valid_ff      <= valid_in;
         op_ff         <= op_in;
         id_ff         <= id_in;
         preset_ff     <= preset_in;
         cyclic_ff     <= cyclic_in;
         idx_ff        <= idx_in;
         pend_ff       <= pend_in;
         out_ff        <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[idx_ff] <= wr_data;
      end
      if (mem_re) begin
         rd_data_ff <= slot_mem[rd_addr];
      end
   end

   assign req.ready       = (state_ff == S_IDLE);
   assign rsp.valid       = out_valid_ff;
   assign rsp.slot_id     = out_ff.slot_id;
   assign rsp.slot_status = out_ff.slot_status;
   assign rsp.error_code  = out_ff.error_code;
   assign rsp.fired       = out_ff.fired;
   assign rsp.last        = out_ff.last;

   // The pending result is always handed on before the sequencer returns to idle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_valid_ff)
      else $error("pending result left behind in idle");

   // An accepted request always starts a walk or a flush.
   assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> (state_ff != S_IDLE))
      else $error("request accepted without being served");

   // A timeout beat never carries an error.
   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.fired) |-> (rsp.error_code == stt_pkg::ERR_NONE))
      else $error("fired result with an error code");

   // Slot memory is written only while a slot is evaluated.
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_EVAL && !is_walk) || (state_ff == S_EVAL))
      else $error("slot memory written outside evaluation");

endmodule

/* bench/tb_software_timer_table_top.sv */
// Testbench for software_timer_table_top: sends request beats, predicts each result beat
// from its own copy of the slot table and checks the results in order, field by field.
// Depends on stt_pkg, the channel interfaces in stt_if.sv and the top level.
module tb_software_timer_table_top;

   localparam int SlotCount    = stt_pkg::TimerCountDef;
   localparam int SlotIdxW     = (SlotCount > 1) ? $clog2(SlotCount) : 1;
   localparam int TickBits     = stt_pkg::TickBitsDef;
   localparam int HoldCycles   = 200;
   localparam int IdleLimit    = 3000;
   localparam int SettleCycles = 20;

   typedef struct packed {
      logic [stt_pkg::ReqTypeW-1:0] req_type;
      logic [stt_pkg::IdW-1:0]      timer_id;
      logic [stt_pkg::PresetW-1:0]  preset;
      logic                         cyclic;
   } req_beat_type;

   logic clock;
   logic reset = 1'b1;

   stt_req_if req_ch ();
   stt_rsp_if rsp_ch ();

   software_timer_table_top DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // Predicted contents of the slot table.
   logic [stt_pkg::StatusW-1:0] tbl_status  [SlotCount];
   logic                        tbl_cyclic  [SlotCount];
   logic [TickBits-1:0]         tbl_preset  [SlotCount];
   logic [TickBits-1:0]         tbl_elapsed [SlotCount];

   stt_pkg::rsp_type expected_rsps [$];
   int      error_count     = 0;
   int      idle_cycles     = 0;
   bit      sender_idling   = 1'b1;
   bit      receiver_idling = 1'b1;
   int      hold_requests   = 0;
   int      holds_served    = 0;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic stt_pkg::rsp_type make_beat(input logic [stt_pkg::IdW-1:0] id,
                                                  input logic [stt_pkg::StatusW-1:0] st,
                                                  input logic [stt_pkg::ErrorW-1:0] err,
                                                  input logic fired, input logic last);
      stt_pkg::rsp_type b;
      b.slot_id     = id;
      b.slot_status = st;
      b.error_code  = err;
      b.fired       = fired;
      b.last        = last;
      return b;
   endfunction

   function automatic req_beat_type beat(input logic [stt_pkg::ReqTypeW-1:0] t,
                                         input int id, input int p, input logic c);
      req_beat_type r;
      r.req_type = t;
      r.timer_id = stt_pkg::IdW'(id);
      r.preset   = stt_pkg::PresetW'(p);
      r.cyclic   = c;
      return r;
   endfunction

   // Applies one accepted request to the slot table copy and queues its result beats.
   task automatic predict_results(input req_beat_type r);
      stt_pkg::rsp_type    held;
      bit                  have_held;
      int                  idx;
      int                  i;
      logic [SlotIdxW-1:0] slot;
      have_held = 1'b0;
      idx = int'(r.timer_id);
      if (r.req_type == stt_pkg::REQ_CREATE) begin
         held = make_beat('0, stt_pkg::ST_UNUSED, stt_pkg::ERR_FULL, 1'b0, 1'b1);
         for (i = 0; i < SlotCount; i++) begin
            slot = SlotIdxW'(i);
            if (!have_held && tbl_status[slot] == stt_pkg::ST_UNUSED) begin
               tbl_status[slot]  = stt_pkg::ST_OFF;
               tbl_cyclic[slot]  = r.cyclic;
               tbl_elapsed[slot] = '0;
               held = make_beat(stt_pkg::IdW'(i), stt_pkg::ST_OFF, stt_pkg::ERR_NONE,
                                1'b0, 1'b1);
               have_held = 1'b1;
            end
         end
         expected_rsps.push_back(held);
      end else if (r.req_type == stt_pkg::REQ_TICK) begin
         // Each fired beat is held back until we know whether it is the final one.
         for (i = 0; i < SlotCount; i++) begin
            slot = SlotIdxW'(i);
            if (tbl_status[slot] == stt_pkg::ST_ON) begin
               tbl_elapsed[slot] = tbl_elapsed[slot] + TickBits'(1);
               if (tbl_elapsed[slot] == tbl_preset[slot]) begin
                  if (tbl_cyclic[slot])
                     tbl_elapsed[slot] = '0;
                  else
                     tbl_status[slot] = stt_pkg::ST_OFF;
                  if (have_held)
                     expected_rsps.push_back(held);
                  held = make_beat(stt_pkg::IdW'(i), tbl_status[slot], stt_pkg::ERR_NONE,
                                   1'b1, 1'b0);
                  have_held = 1'b1;
               end
            end
         end
         if (have_held) begin
            held.last = 1'b1;
            expected_rsps.push_back(held);
         end
      end else if (idx >= SlotCount) begin
         expected_rsps.push_back(make_beat(r.timer_id, stt_pkg::ST_UNUSED,
                                           stt_pkg::ERR_RANGE, 1'b0, 1'b1));
      end else begin
         slot = r.timer_id[SlotIdxW-1:0];
         if (r.req_type == stt_pkg::REQ_REMOVE) begin
            tbl_status[slot]  = stt_pkg::ST_UNUSED;
            tbl_cyclic[slot]  = 1'b0;
            tbl_preset[slot]  = '0;
            tbl_elapsed[slot] = '0;
         end else if (r.req_type != stt_pkg::REQ_STATUS &&
                      tbl_status[slot] != stt_pkg::ST_UNUSED) begin
            case (r.req_type)
               stt_pkg::REQ_START: begin
                  tbl_elapsed[slot] = '0;
                  tbl_preset[slot]  = r.preset[TickBits-1:0];
                  tbl_status[slot]  = stt_pkg::ST_ON;
               end
               stt_pkg::REQ_STOP:  tbl_status[slot] = stt_pkg::ST_OFF;
               stt_pkg::REQ_PAUSE: tbl_status[slot] = stt_pkg::ST_PAUSED;
               default:            tbl_status[slot] = stt_pkg::ST_ON;
            endcase
         end
         expected_rsps.push_back(make_beat(r.timer_id, tbl_status[slot], stt_pkg::ERR_NONE,
                                           1'b0, 1'b1));
      end
   endtask

   // Offers one request beat, with an optional gap first, and waits for acceptance.
   task automatic send_request(input req_beat_type r);
      if (sender_idling && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
         repeat ($urandom_range(0, 13)) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid    = 1'b1;
      req_ch.req_type = r.req_type;
      req_ch.timer_id = r.timer_id;
      req_ch.preset   = r.preset;
      req_ch.cyclic   = r.cyclic;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_results(r);
   endtask

   // Stops offering and waits until every predicted beat has been taken.
   task automatic wait_for_drain();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   function automatic req_beat_type random_request();
      req_beat_type r;
      int           pick;
      r.timer_id = stt_pkg::IdW'($urandom_range(0, 63));
      r.preset   = stt_pkg::PresetW'($urandom);
      r.cyclic   = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 34)
         r.req_type = stt_pkg::REQ_TICK;
      else if (pick < 46)
         r.req_type = stt_pkg::REQ_CREATE;
      else if (pick < 60)
         r.req_type = stt_pkg::REQ_START;
      else if (pick < 66)
         r.req_type = stt_pkg::REQ_STOP;
      else if (pick < 72)
         r.req_type = stt_pkg::REQ_PAUSE;
      else if (pick < 78)
         r.req_type = stt_pkg::REQ_CONTINUE;
      else if (pick < 86)
         r.req_type = stt_pkg::REQ_REMOVE;
      else
         r.req_type = stt_pkg::REQ_STATUS;
      // Most requests address a real slot; the rest draw from the full id range, mostly for the range check.
      if ($urandom_range(0, 9) != 0)
         r.timer_id = stt_pkg::IdW'($urandom_range(0, SlotCount - 1));
      // Short presets let timers fire within a few ticks.
      if (r.req_type == stt_pkg::REQ_START && $urandom_range(0, 7) != 0)
         r.preset = stt_pkg::PresetW'($urandom_range(1, 6));
      return r;
   endfunction

   task automatic test_directed();
      int i;
      send_request(beat(stt_pkg::REQ_TICK, 0, 0, 1'b0));
      send_request(beat(stt_pkg::REQ_STATUS, 0, 'hFFFF, 1'b1));
      send_request(beat(stt_pkg::REQ_START, 3, 5, 1'b0));
      send_request(beat(stt_pkg::REQ_CONTINUE, 5, 0, 1'b0));
      send_request(beat(stt_pkg::REQ_REMOVE, 2, 0, 1'b1));
      send_request(beat(stt_pkg::REQ_START, 63, 'hFFFF, 1'b1));
      send_request(beat(stt_pkg::REQ_PAUSE, 8, 0, 1'b0));
      send_request(beat(stt_pkg::REQ_REMOVE, 63, 0, 1'b0));
      send_request(beat(stt_pkg::REQ_STATUS, 8, 0, 1'b0));
      for (i = 0; i < SlotCount; i++)
         send_request(beat(stt_pkg::REQ_CREATE, 63 - i, 'hFFFF, 1'(i)));
      send_request(beat(stt_pkg::REQ_CREATE, 0, 0, 1'b1));
      send_request(beat(stt_pkg::REQ_START, 0, 1, 1'b0));
      send_request(beat(stt_pkg::REQ_START, 1, 1, 1'b0));
      send_request(beat(stt_pkg::REQ_START, 2, 'hFFFF, 1'b0));
      send_request(beat(stt_pkg::REQ_START, 4, 0, 1'b0));
      send_request(beat(stt_pkg::REQ_TICK, 42, 'hFFFF, 1'b1));
      send_request(beat(stt_pkg::REQ_PAUSE, 1, 0, 1'b0));
      send_request(beat(stt_pkg::REQ_STOP, 2, 0, 1'b0));
      // An off slot that is continued runs on from the count it had.
      send_request(beat(stt_pkg::REQ_CONTINUE, 2, 0, 1'b0));
      send_request(beat(stt_pkg::REQ_TICK, 0, 0, 1'b0));
      send_request(beat(stt_pkg::REQ_REMOVE, 7, 0, 1'b0));
      send_request(beat(stt_pkg::REQ_CREATE, 0, 0, 1'b0));
   endtask

   task automatic test_random_traffic(input int count);
      repeat (count) send_request(random_request());
   endtask

   // The receiver stalls for a long stretch while requests keep coming, then the
   // sender waits for the table to drain completely.
   task automatic test_backpressure();
      sender_idling = 1'b0;
      hold_requests++;
      repeat (12) send_request(random_request());
      sender_idling = 1'b1;
      wait_for_drain();
   endtask

   task automatic test_full_rate(input int count);
      sender_idling   = 1'b0;
      receiver_idling = 1'b0;
      test_random_traffic(count);
   endtask

   task automatic check_field(input string name, input logic [15:0] exp_val,
                              input logic [15:0] act_val);
      if (exp_val !== act_val) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
                  act_val);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : rsp_checker
      stt_pkg::rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual slot_id %0d",
                     $time, rsp_ch.slot_id);
            error_count++;
         end else begin
            want = expected_rsps.pop_front();
            check_field("slot_id", 16'(want.slot_id), 16'(rsp_ch.slot_id));
            check_field("slot_status", 16'(want.slot_status), 16'(rsp_ch.slot_status));
            check_field("error_code", 16'(want.error_code), 16'(rsp_ch.error_code));
            check_field("fired", 16'(want.fired), 16'(rsp_ch.fired));
            check_field("last", 16'(want.last), 16'(rsp_ch.last));
         end
      end
   end

   initial begin : rsp_receiver
      rsp_ch.ready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (holds_served != hold_requests) begin
            rsp_ch.ready = 1'b0;
            repeat (HoldCycles - 1) @(negedge clock);
            holds_served++;
         end else if (receiver_idling && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready = 1'b0;
            repeat ($urandom_range(0, 13)) @(negedge clock);
         end else begin
            rsp_ch.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int                  i;
      logic [SlotIdxW-1:0] slot;
      req_ch.valid    = 1'b0;
      req_ch.req_type = stt_pkg::REQ_CREATE;
      req_ch.timer_id = '0;
      req_ch.preset   = '0;
      req_ch.cyclic   = 1'b0;
      for (i = 0; i < SlotCount; i++) begin
         slot = SlotIdxW'(i);
         tbl_status[slot]  = stt_pkg::ST_UNUSED;
         tbl_cyclic[slot]  = 1'b0;
         tbl_preset[slot]  = '0;
         tbl_elapsed[slot] = '0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random_traffic(200);
      test_backpressure();
      test_random_traffic(200);
      test_full_rate(40);
      wait_for_drain();

      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
